// ===== design/rppe_pkg.sv =====
// Package for the rotated pixel plot engine: sizes, field widths and codes.
// Depends on nothing; used by the top level by scoped names.
package rppe_pkg;

  localparam int unsigned FRAME_BYTES = 131072;
  localparam int unsigned COORD_BITS  = 10;

  // Store address width and derived address arithmetic widths.
  localparam int unsigned ADDR_W  = $clog2(FRAME_BYTES);
  localparam int unsigned PL_W    = COORD_BITS - 3;        // bytes per line
  localparam int unsigned PROD_W  = COORD_BITS + PL_W;     // line * bytes per line
  localparam int unsigned Z_W     = PROD_W + 1;            // full byte address sum

  // Fixed field widths.
  localparam int unsigned RADDR_W   = 17;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned BYTE_W    = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_ORIENT = 3'd2,
    REG_INVERT = 3'd3,
    REG_SPLIT  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PEN_WHITE = 2'd0,
    PEN_BLACK = 2'd1,
    PEN_GREY  = 2'd2,
    PEN_OTHER = 2'd3
  } pen_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } orient_e;

  typedef enum logic {
    REQ_PLOT = 1'b0,
    REQ_READ = 1'b1
  } req_e;

endpackage

// ===== design/rppe_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// Self-contained; read data updates only on a read enable.
module rppe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/rotated_pixel_plot_engine_unit.sv =====
// Rotated pixel plot engine: 1 bit per pixel frame store with plot and byte read.
// Sequence: a plot word passes the rotate, address, read and modify states, a read
// word skips the address state; the result is registered on leaving modify. One word
// at a time, set by the read-modify-write sequence on the single port of the frame store RAM.
// Reset: control and configuration registers take their reset values at once; then a clearing pass
// writes zero to all 131072 bytes, one per cycle, with in_stall_o held high.
module rotated_pixel_plot_engine_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               req_type_i,
  input  logic [rppe_pkg::COORD_BITS-1:0]    coord_x_i,
  input  logic [rppe_pkg::COORD_BITS-1:0]    coord_y_i,
  input  logic [1:0]                         pen_colour_i,
  input  logic [rppe_pkg::RADDR_W-1:0]       read_address_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               status_o,
  output logic [rppe_pkg::BYTE_W-1:0]        read_data_o,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rppe_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rppe_pkg::COORD_BITS-1:0]    cfg_data_i
);

  localparam int unsigned CW = rppe_pkg::COORD_BITS;
  localparam int unsigned AW = rppe_pkg::ADDR_W;
  localparam int unsigned PW = rppe_pkg::PL_W;
  localparam int unsigned MW = rppe_pkg::PROD_W;
  localparam int unsigned ZW = rppe_pkg::Z_W;
  localparam int unsigned BW = rppe_pkg::BYTE_W;

  // Sequencer codes.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ROT  = 3'd1;  // rotate, clip, pick the bit
  localparam logic [2:0] ST_ADDR = 3'd2;  // line multiply, byte address
  localparam logic [2:0] ST_READ = 3'd3;  // issue store read
  localparam logic [2:0] ST_MOD  = 3'd4;  // modify, write back, deliver

  // ---------------------------------------------------------------------------
  // Configuration registers. The port is always ready; the user must write only
  // while the engine is idle (the block does not enforce it), so no word in flight sees a change.
  // ---------------------------------------------------------------------------
  logic [CW-1:0] width_q, height_q;
  logic [1:0]    orient_q;
  logic          invert_q, split_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CW'(152);
      height_q <= CW'(296);
      orient_q <= rppe_pkg::ROT_0;
      invert_q <= 1'b0;
      split_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rppe_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        rppe_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        rppe_pkg::REG_ORIENT: orient_q <= cfg_data_i[1:0];
        rppe_pkg::REG_INVERT: invert_q <= cfg_data_i[0];
        rppe_pkg::REG_SPLIT:  split_q  <= cfg_data_i[0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Control state: sequencer, result valid, clearing pass.
  // ---------------------------------------------------------------------------
  logic [2:0]    state_q, state_d;
  logic          out_valid_q, out_valid_d;
  logic          clr_active_q;
  logic [AW-1:0] clr_addr_q;

  logic in_take, out_free, deliver;

  assign in_stall_o = clr_active_q || (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign deliver    = (state_q == ST_MOD) && out_free;

  // Request word, held for the whole sequence.
  logic          req_q;
  logic [CW-1:0] x_q, y_q;
  logic [1:0]    pen_q;
  logic [rppe_pkg::RADDR_W-1:0] raddr_q;

  // Results of the rotate step.
  logic          on_q;
  logic [CW-1:0] line_q, colp_q;
  logic          upper_q;
  logic [PW-1:0] mul_q;
  logic [MW-1:0] off_q;
  logic [BW-1:0] mask_q;
  logic          set_q, clr_q;

  // Results of the address step.
  logic [AW-1:0] addr_q;
  logic          drop_q;

  // Result payload.
  logic          status_q;
  logic [BW-1:0] rdout_q;

  // ---------------------------------------------------------------------------
  // Rotate and clip. Line runs along the long dimension, column across.
  // ---------------------------------------------------------------------------
  logic          on_c;
  logic [CW-1:0] line_c, col_c, half_c, colp_c;
  logic          upper_c;
  logic [PW-1:0] per_line_c, mul_c;
  logic [MW-1:0] off_c;
  logic [1:0]    pen_c;
  logic          white_c, black_c, clr_c, set_c;
  logic [31:0]   raddr_ext_c;
  logic          rd_in_range_c;

  always_comb begin
    unique case (orient_q)
      rppe_pkg::ROT_0: begin
        on_c   = (x_q < width_q) && (y_q < height_q);
        line_c = y_q;
        col_c  = x_q;
      end
      rppe_pkg::ROT_90: begin
        on_c   = (x_q < height_q) && (y_q < width_q);
        line_c = x_q;
        col_c  = width_q - CW'(1) - y_q;
      end
      rppe_pkg::ROT_180: begin
        on_c   = (x_q < width_q) && (y_q < height_q);
        line_c = height_q - CW'(1) - y_q;
        col_c  = width_q - CW'(1) - x_q;
      end
      rppe_pkg::ROT_270: begin
        on_c   = (x_q < height_q) && (y_q < width_q);
        line_c = height_q - CW'(1) - x_q;
        col_c  = y_q;
      end
      default: begin
        on_c   = 1'b0;
        line_c = '0;
        col_c  = '0;
      end
    endcase

    // Half-page mode: right half of a line moves to the second half-page.
    per_line_c = width_q[CW-1:3];
    half_c     = width_q >> 1;
    upper_c    = split_q && (col_c >= half_c);
    colp_c     = upper_c ? (col_c - half_c) : col_c;
    mul_c      = split_q ? (per_line_c >> 1) : per_line_c;
    off_c      = (MW'(height_q) * MW'(per_line_c)) >> 1;

    // Grey resolves to a checkerboard on the rotated parity.
    if (pen_q == rppe_pkg::PEN_GREY) begin
      pen_c = (line_c[0] ^ col_c[0]) ? rppe_pkg::PEN_WHITE : rppe_pkg::PEN_BLACK;
    end else begin
      pen_c = pen_q;
    end
    white_c = (pen_c == rppe_pkg::PEN_WHITE);
    black_c = (pen_c == rppe_pkg::PEN_BLACK);
    clr_c   = white_c != invert_q;
    set_c   = !clr_c && (black_c != invert_q);

    raddr_ext_c   = 32'(raddr_q);
    rd_in_range_c = raddr_ext_c < 32'(rppe_pkg::FRAME_BYTES);
  end

  // ---------------------------------------------------------------------------
  // Byte address: one multiply, then offset and range check.
  // ---------------------------------------------------------------------------
  logic [MW-1:0] prod_c;
  logic [ZW-1:0] z_c;
  logic [31:0]   z_ext_c;
  logic          z_over_c;

  always_comb begin
    prod_c   = MW'(line_q) * MW'(mul_q);
    z_c      = ZW'(prod_c) + ZW'(colp_q >> 3) + (upper_q ? ZW'(off_q) : ZW'(0));
    z_ext_c  = 32'(z_c);
    z_over_c = z_ext_c >= 32'(rppe_pkg::FRAME_BYTES);
  end

  // ---------------------------------------------------------------------------
  // Frame store and the read-modify-write. One word is in flight at a time, so
  // a write back always lands before the next read; no forwarding needed.
  // ---------------------------------------------------------------------------
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [BW-1:0] ram_wdata, ram_rdata;
  logic [BW-1:0] new_byte_c;
  logic          plot_write_c;

  always_comb begin
    if (clr_q) begin
      new_byte_c = ram_rdata & ~mask_q;
    end else begin
      new_byte_c = ram_rdata | mask_q;
    end
    plot_write_c = deliver && (req_q == rppe_pkg::REQ_PLOT) && !drop_q && (set_q || clr_q);

    ram_we    = clr_active_q || plot_write_c;
    ram_re    = (state_q == ST_READ) && !clr_active_q;
    ram_addr  = clr_active_q ? clr_addr_q : addr_q;
    ram_wdata = clr_active_q ? '0 : new_byte_c;
  end

  rppe_ram #(
    .WIDTH (BW),
    .DEPTH (rppe_pkg::FRAME_BYTES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: if (in_take) state_d = ST_ROT;
      ST_ROT:  state_d = (req_q == rppe_pkg::REQ_READ) ? ST_READ : ST_ADDR;
      ST_ADDR: state_d = ST_READ;
      ST_READ: state_d = ST_MOD;
      ST_MOD: begin
        // Hold here until the result register can take the word.
        if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (clr_active_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(rppe_pkg::FRAME_BYTES - 1)) begin
          clr_active_q <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q   <= req_type_i;
      x_q     <= coord_x_i;
      y_q     <= coord_y_i;
      pen_q   <= pen_colour_i;
      raddr_q <= read_address_i;
    end

    if (state_q == ST_ROT) begin
      on_q    <= on_c;
      line_q  <= line_c;
      colp_q  <= colp_c;
      upper_q <= upper_c;
      mul_q   <= mul_c;
      off_q   <= off_c;
      mask_q  <= BW'(8'h80) >> col_c[2:0];
      set_q   <= set_c;
      clr_q   <= clr_c;
      // Reads skip the address step: take the request address directly.
      addr_q  <= raddr_ext_c[AW-1:0];
      drop_q  <= !rd_in_range_c;
    end

    if (state_q == ST_ADDR) begin
      addr_q <= z_ext_c[AW-1:0];
      drop_q <= !on_q || z_over_c;
    end

    if (deliver) begin
      if (req_q == rppe_pkg::REQ_READ) begin
        status_q <= 1'b0;
        rdout_q  <= drop_q ? '0 : ram_rdata;
      end else begin
        status_q <= drop_q;
        rdout_q  <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign read_data_o = rdout_q;

endmodule
